// File: rtl/ille_pkg.sv
// Shared field widths, command codes and status codes of the linked list engine.
package ille_pkg;

  localparam int CMD_W        = 3;
  localparam int POS_W        = 7;
  localparam int PAYLOAD_W    = 56;
  localparam int STATUS_W     = 3;
  localparam int NODE_INDEX_W = 6;

  localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WALK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_NEW_INDEX = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WALK_ITEM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ERROR     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

// File: rtl/ille_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
module ille_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ille_ctrl.sv
// Command sequencer: head and fill registers, table accesses and result register.
module ille_ctrl import ille_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_BYTES = 7,
  parameter int IDX_W         = $clog2(CAPACITY),
  parameter int LNK_W         = IDX_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [CMD_W-1:0]        command,
  input  logic signed [POS_W-1:0] position,
  input  logic signed [POS_W-1:0] link,
  input  logic [PAYLOAD_W-1:0]    payload,
  output logic                    busy,
  output logic                    strobe,
  output logic [STATUS_W-1:0]     status,
  output logic [NODE_INDEX_W-1:0] node_index,
  output logic [PAYLOAD_W-1:0]    node_data,
  output logic                    last_item,
  output logic [IDX_W-1:0]        rd_addr,
  output logic                    link_we,
  output logic [IDX_W-1:0]        link_waddr,
  output logic [LNK_W-1:0]        link_wdata,
  input  logic [LNK_W-1:0]        link_rdata,
  output logic                    data_we,
  output logic [IDX_W-1:0]        data_waddr,
  output logic [PAYLOAD_W-1:0]    data_wdata,
  input  logic [PAYLOAD_W-1:0]    data_rdata
);

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PAY_BITS = (PAYLOAD_BYTES * 8 < PAYLOAD_W) ? PAYLOAD_BYTES * 8 : PAYLOAD_W;
  localparam logic [PAYLOAD_W-1:0] PAY_MASK = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - PAY_BITS);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_DEL_POS = 3'd2;
  localparam logic [2:0] S_DEL_FIN = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;

  function automatic logic [LNK_W-1:0] to_link(input logic [POS_W-1:0] raw);
    logic nul;
    nul = raw[POS_W-1] || ({1'b0, raw[POS_W-2:0]} >= POS_W'(CAPACITY));
    return {nul, raw[IDX_W-1:0]};
  endfunction

  logic [2:0]       state, state_next;
  logic [LNK_W-1:0] head, head_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [IDX_W-1:0] pos_r, pos_next;
  logic [IDX_W-1:0] victim, victim_next;
  logic             del_head, del_head_next;
  logic [IDX_W-1:0] walk_k, walk_k_next;

  logic                    strobe_next;
  logic [STATUS_W-1:0]     status_next;
  logic [IDX_W-1:0]        index_next;
  logic [PAYLOAD_W-1:0]    data_next;
  logic                    last_next;

  logic [LNK_W-1:0] pos_l, lnk_l;
  logic [IDX_W-1:0] n_idx;
  logic             full, bad_pos, walk_end;

  assign pos_l   = to_link(position);
  assign lnk_l   = to_link(link);
  assign n_idx   = fill[IDX_W-1:0];
  assign full    = (fill == FULL);
  assign bad_pos = !pos_l[IDX_W] && (CNT_W'(pos_l[IDX_W-1:0]) >= fill);
  assign walk_end = link_rdata[IDX_W] || (walk_k == LAST_K);
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    head_next     = head;
    fill_next     = fill;
    pos_next      = pos_r;
    victim_next   = victim;
    del_head_next = del_head;
    walk_k_next   = walk_k;
    strobe_next   = 1'b0;
    status_next   = ST_ERROR;
    index_next    = '0;
    data_next     = '0;
    last_next     = 1'b1;
    rd_addr       = pos_l[IDX_W-1:0];
    link_we       = 1'b0;
    link_waddr    = n_idx;
    link_wdata    = lnk_l;
    data_we       = 1'b0;
    data_waddr    = n_idx;
    data_wdata    = payload & PAY_MASK;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_START: begin
              head_next = lnk_l;
              fill_next = '0;
            end
            CMD_LOAD: begin
              strobe_next = 1'b1;
              if (!full) begin
                link_we     = 1'b1;
                data_we     = 1'b1;
                fill_next   = fill + 1'b1;
                status_next = ST_NEW_INDEX;
                index_next  = n_idx;
              end
            end
            CMD_INSERT: begin
              if (full || bad_pos) begin
                strobe_next = 1'b1;
              end else begin
                data_we   = 1'b1;
                fill_next = fill + 1'b1;
                pos_next  = n_idx;
                if (pos_l[IDX_W]) begin
                  link_we     = 1'b1;
                  link_wdata  = head;
                  head_next   = {1'b0, n_idx};
                  strobe_next = 1'b1;
                  status_next = ST_NEW_INDEX;
                  index_next  = n_idx;
                end else begin
                  link_we    = 1'b1;
                  link_waddr = pos_l[IDX_W-1:0];
                  link_wdata = {1'b0, n_idx};
                  state_next = S_INS;
                end
              end
            end
            CMD_DELETE: begin
              if (pos_l[IDX_W]) begin
                if (head[IDX_W]) begin
                  strobe_next = 1'b1;
                end else begin
                  rd_addr       = head[IDX_W-1:0];
                  victim_next   = head[IDX_W-1:0];
                  del_head_next = 1'b1;
                  state_next    = S_DEL_FIN;
                end
              end else if (bad_pos) begin
                strobe_next = 1'b1;
              end else begin
                pos_next      = pos_l[IDX_W-1:0];
                del_head_next = 1'b0;
                state_next    = S_DEL_POS;
              end
            end
            CMD_WALK: begin
              if (head[IDX_W]) begin
                strobe_next = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                rd_addr     = head[IDX_W-1:0];
                victim_next = head[IDX_W-1:0];
                walk_k_next = '0;
                state_next  = S_WALK;
              end
            end
            default: begin
              strobe_next = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        link_we     = 1'b1;
        link_waddr  = pos_r;
        link_wdata  = link_rdata;
        strobe_next = 1'b1;
        status_next = ST_NEW_INDEX;
        index_next  = pos_r;
        state_next  = S_IDLE;
      end
      S_DEL_POS: begin
        rd_addr     = link_rdata[IDX_W-1:0];
        victim_next = link_rdata[IDX_W-1:0];
        if (link_rdata[IDX_W]) begin
          strobe_next = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_DEL_FIN;
        end
      end
      S_DEL_FIN: begin
        if (del_head) begin
          head_next = link_rdata;
        end else begin
          link_we    = 1'b1;
          link_waddr = pos_r;
          link_wdata = link_rdata;
        end
        strobe_next = 1'b1;
        status_next = ST_REMOVED;
        index_next  = victim;
        data_next   = data_rdata;
        state_next  = S_IDLE;
      end
      S_WALK: begin
        strobe_next = 1'b1;
        status_next = ST_WALK_ITEM;
        index_next  = victim;
        data_next   = data_rdata;
        last_next   = walk_end;
        rd_addr     = link_rdata[IDX_W-1:0];
        if (walk_end) begin
          state_next = S_IDLE;
        end else begin
          victim_next = link_rdata[IDX_W-1:0];
          walk_k_next = walk_k + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= {LNK_W{1'b1}};
      fill   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      fill   <= fill_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_next;
    victim     <= victim_next;
    del_head   <= del_head_next;
    walk_k     <= walk_k_next;
    status     <= status_next;
    node_index <= NODE_INDEX_W'(index_next);
    node_data  <= data_next;
    last_item  <= last_next;
  end

endmodule

// File: rtl/indexed_linked_list_engine.sv
// Top level of the indexed singly linked list engine.
//
// An item is taken when start is high and busy is low. Each result appears for
// one cycle with strobe high; the receiver cannot hold it off. Path from
// acceptance to the result:
//   start                       no result, ready again the next cycle
//   load, insert at head,
//   empty walk, any error found
//   from registers              result registered directly, busy stays low
//   insert after a position     via S_INS (link read, then link write)
//   delete at head              via S_DEL_FIN
//   delete after a position     via S_DEL_POS, S_DEL_FIN (two dependent link reads)
//   walk of N nodes             via S_WALK, one node per cycle
// The rate is set by the single read port of the link table: each step of a
// chain waits for the registered read of the previous link.
// Reset clears the head to null and the fill count to zero; table contents
// stay undefined until loaded or inserted.
module indexed_linked_list_engine import ille_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_BYTES = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [CMD_W-1:0]        command,
  input  logic signed [POS_W-1:0] position,
  input  logic signed [POS_W-1:0] link,
  input  logic [PAYLOAD_W-1:0]    payload,
  output logic                    busy,
  output logic                    strobe,
  output logic [STATUS_W-1:0]     status,
  output logic [NODE_INDEX_W-1:0] node_index,
  output logic [PAYLOAD_W-1:0]    node_data,
  output logic                    last_item
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LNK_W = IDX_W + 1;

  logic [IDX_W-1:0]     rd_addr;
  logic                 link_we;
  logic [IDX_W-1:0]     link_waddr;
  logic [LNK_W-1:0]     link_wdata;
  logic [LNK_W-1:0]     link_rdata;
  logic                 data_we;
  logic [IDX_W-1:0]     data_waddr;
  logic [PAYLOAD_W-1:0] data_wdata;
  logic [PAYLOAD_W-1:0] data_rdata;

  ille_ram #(
    .WIDTH (LNK_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  ille_ram #(
    .WIDTH (PAYLOAD_W),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  ille_ctrl #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .IDX_W         (IDX_W),
    .LNK_W         (LNK_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .position   (position),
    .link       (link),
    .payload    (payload),
    .busy       (busy),
    .strobe     (strobe),
    .status     (status),
    .node_index (node_index),
    .node_data  (node_data),
    .last_item  (last_item),
    .rd_addr    (rd_addr),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_rdata (link_rdata),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .data_rdata (data_rdata)
  );

endmodule

// File: sim/ille_checker.sv
// Checker for the linked list engine: predicts every result of each item and compares fields.
module ille_checker import ille_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [CMD_W-1:0]        command,
  input  logic signed [POS_W-1:0] position,
  input  logic signed [POS_W-1:0] link,
  input  logic [PAYLOAD_W-1:0]    payload,
  input  logic                    strobe,
  input  logic [STATUS_W-1:0]     status,
  input  logic [NODE_INDEX_W-1:0] node_index,
  input  logic [PAYLOAD_W-1:0]    node_data,
  input  logic                    last_item,
  output int                      failures,
  output int                      pending
);

  localparam int NO_SLOT = -1;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [NODE_INDEX_W-1:0] node_index;
    logic [PAYLOAD_W-1:0]    node_data;
    logic                    last_item;
  } list_report_t;

  logic [PAYLOAD_W-1:0] slot_data [CAPACITY];
  int                   slot_next [CAPACITY];
  int                   head_slot;
  int                   fill_level;
  list_report_t         reports_due [$];

  function automatic int as_slot(logic signed [POS_W-1:0] raw);
    int v;
    v = int'(raw);
    return (v < 0 || v >= CAPACITY) ? NO_SLOT : v;
  endfunction

  task automatic post_report(logic [STATUS_W-1:0] st, int idx, logic [PAYLOAD_W-1:0] d,
                             logic fin);
    list_report_t r;
    r.status     = st;
    r.node_index = (idx < 0) ? '0 : NODE_INDEX_W'(idx);
    r.node_data  = d;
    r.last_item  = fin;
    reports_due.push_back(r);
  endtask

  task automatic run_list_command(logic [CMD_W-1:0] cmd, int pos, int lnk,
                                  logic [PAYLOAD_W-1:0] pay);
    int n;
    int victim;
    int p;
    int nxt;
    int k;
    n = fill_level;
    case (cmd)
      CMD_START: begin
        head_slot  = lnk;
        fill_level = 0;
      end
      CMD_LOAD: begin
        if (n >= CAPACITY) begin
          post_report(ST_ERROR, 0, '0, 1'b1);
        end else begin
          slot_data[n] = pay;
          slot_next[n] = lnk;
          fill_level   = n + 1;
          post_report(ST_NEW_INDEX, n, '0, 1'b1);
        end
      end
      CMD_INSERT: begin
        if (n >= CAPACITY || (pos != NO_SLOT && pos >= n)) begin
          post_report(ST_ERROR, 0, '0, 1'b1);
        end else begin
          slot_data[n] = pay;
          if (pos == NO_SLOT) begin
            slot_next[n] = head_slot;
            head_slot    = n;
          end else begin
            slot_next[n]   = slot_next[pos];
            slot_next[pos] = n;
          end
          fill_level = n + 1;
          post_report(ST_NEW_INDEX, n, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        victim = NO_SLOT;
        if (pos == NO_SLOT) victim = head_slot;
        else if (pos < n) victim = slot_next[pos];
        if (victim == NO_SLOT) begin
          post_report(ST_ERROR, 0, '0, 1'b1);
        end else begin
          if (pos == NO_SLOT) head_slot = slot_next[victim];
          else slot_next[pos] = slot_next[victim];
          post_report(ST_REMOVED, victim, slot_data[victim], 1'b1);
        end
      end
      CMD_WALK: begin
        if (head_slot == NO_SLOT) begin
          post_report(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          p = head_slot;
          k = 0;
          // stop a cyclic list after one table's worth of nodes
          while (p != NO_SLOT && k < CAPACITY) begin
            nxt = slot_next[p];
            post_report(ST_WALK_ITEM, p, slot_data[p], nxt == NO_SLOT || k + 1 == CAPACITY);
            k++;
            p = nxt;
          end
        end
      end
      default: begin
        post_report(ST_ERROR, 0, '0, 1'b1);
      end
    endcase
  endtask

  // sample midway through the cycle, where inputs and outputs are settled
  always @(negedge clk) begin
    list_report_t want;
    if (rst) begin
      head_slot  = NO_SLOT;
      fill_level = 0;
      reports_due.delete();
      for (int i = 0; i < CAPACITY; i++) begin
        slot_data[i] = '0;
        slot_next[i] = 0;
      end
    end else begin
      if (strobe === 1'b1) begin
        if (reports_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected result: expected none, actual status %0d index %0d data %h last %0b",
                   $time, status, node_index, node_data, last_item);
        end else begin
          want = reports_due.pop_front();
          if (status !== want.status) begin
            failures++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
          end
          if (node_index !== want.node_index) begin
            failures++;
            $display("%0t: node_index mismatch: expected %0d actual %0d",
                     $time, want.node_index, node_index);
          end
          if (node_data !== want.node_data) begin
            failures++;
            $display("%0t: node_data mismatch: expected %h actual %h",
                     $time, want.node_data, node_data);
          end
          if (last_item !== want.last_item) begin
            failures++;
            $display("%0t: last_item mismatch: expected %0b actual %0b",
                     $time, want.last_item, last_item);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        run_list_command(command, as_slot(position), as_slot(link), payload);
      end
    end
    pending = reports_due.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the linked list engine testbench: clock, reset, command stimulus and the verdict.
module testbench import ille_pkg::*;;

  localparam int CAPACITY    = 64;
  localparam int NULL_SLOT   = -1;
  localparam int ITEM_TARGET = 320;
  localparam int QUIET_FROM  = 140;
  localparam int QUIET_TO    = 220;
  localparam logic [CMD_W-1:0] CMD_TOP = '1;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic [CMD_W-1:0]        command;
  logic signed [POS_W-1:0] position;
  logic signed [POS_W-1:0] link;
  logic [PAYLOAD_W-1:0]    payload;
  logic                    busy;
  logic                    strobe;
  logic [STATUS_W-1:0]     status;
  logic [NODE_INDEX_W-1:0] node_index;
  logic [PAYLOAD_W-1:0]    node_data;
  logic                    last_item;
  int                      failures;
  int                      pending;

  int                      items_sent;
  int                      fill_level;
  bit [CAPACITY-1:0]       slot_loaded;

  indexed_linked_list_engine #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BYTES (7)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .position   (position),
    .link       (link),
    .payload    (payload),
    .busy       (busy),
    .strobe     (strobe),
    .status     (status),
    .node_index (node_index),
    .node_data  (node_data),
    .last_item  (last_item)
  );

  ille_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .position   (position),
    .link       (link),
    .payload    (payload),
    .strobe     (strobe),
    .status     (status),
    .node_index (node_index),
    .node_data  (node_data),
    .last_item  (last_item),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int rand_field();
    int v;
    v = $urandom_range(0, 127);
    return v - 64;
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[PAYLOAD_W-1:0];
  endfunction

  function automatic int rand_null();
    int v;
    v = $urandom_range(1, 64);
    return ($urandom_range(0, 2) == 0) ? -v : NULL_SLOT;
  endfunction

  function automatic int pick_written_slot();
    int s0;
    s0 = $urandom_range(0, CAPACITY - 1);
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_loaded[(s0 + i) % CAPACITY]) return (s0 + i) % CAPACITY;
    end
    return NULL_SLOT;
  endfunction

  function automatic int pick_head();
    return ($urandom_range(0, 9) < 3) ? rand_null() : pick_written_slot();
  endfunction

  task automatic issue(logic [CMD_W-1:0] cmd, int pos, int lnk, logic [PAYLOAD_W-1:0] pay);
    bit taken;
    if (items_sent < QUIET_FROM || items_sent >= QUIET_TO) begin
      while ($urandom_range(0, 99) < 19) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start    <= 1'b1;
    command  <= cmd;
    position <= POS_W'(pos);
    link     <= POS_W'(lnk);
    payload  <= pay;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    // track fill and written slots so that no read of an unwritten slot is caused
    case (cmd)
      CMD_START: fill_level = 0;
      CMD_LOAD: begin
        if (fill_level < CAPACITY) begin
          slot_loaded[fill_level] = 1'b1;
          fill_level++;
        end
      end
      CMD_INSERT: begin
        if (fill_level < CAPACITY && (pos < 0 || pos < fill_level)) begin
          slot_loaded[fill_level] = 1'b1;
          fill_level++;
        end
      end
      default: ;
    endcase
    items_sent++;
  endtask

  // load consecutive slots, each linking to the next, ending on null or a written slot
  task automatic build_chain(int len);
    int tail;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) tail = ($urandom_range(0, 2) == 0) ? pick_written_slot() : rand_null();
      else tail = fill_level + 1;
      issue(CMD_LOAD, rand_field(), tail, rand_payload());
    end
  endtask

  initial begin
    int round;
    int r;
    int n;
    rst         <= 1'b1;
    start       <= 1'b0;
    command     <= CMD_START;
    position    <= '0;
    link        <= '0;
    payload     <= '0;
    items_sent  = 0;
    fill_level  = 0;
    slot_loaded = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(CMD_WALK, rand_field(), rand_field(), rand_payload());
    issue(CMD_DELETE, NULL_SLOT, rand_field(), rand_payload());
    for (int c = CMD_WALK + 1; c <= CMD_TOP; c++) begin
      issue(CMD_W'(c), rand_field(), rand_field(), rand_payload());
    end
    issue(CMD_INSERT, CAPACITY - 1, rand_field(), rand_payload());
    issue(CMD_DELETE, 0, rand_field(), rand_payload());
    issue(CMD_LOAD, -CAPACITY, 1, '1);
    issue(CMD_LOAD, CAPACITY - 1, 2, '0);
    issue(CMD_LOAD, 0, NULL_SLOT, {7{8'hAA}});
    issue(CMD_INSERT, 0, rand_field(), {7{8'h55}});
    issue(CMD_INSERT, NULL_SLOT, rand_field(), rand_payload());
    issue(CMD_START, rand_field(), 0, rand_payload());
    issue(CMD_WALK, rand_field(), rand_field(), rand_payload());
    issue(CMD_DELETE, -CAPACITY, rand_field(), rand_payload());
    issue(CMD_WALK, rand_field(), rand_field(), rand_payload());
    issue(CMD_INSERT, NULL_SLOT, rand_field(), rand_payload());
    repeat (4) issue(CMD_DELETE, 0, rand_field(), rand_payload());
    issue(CMD_LOAD, rand_field(), 1, rand_payload());
    issue(CMD_START, rand_field(), 1, rand_payload());
    issue(CMD_WALK, rand_field(), rand_field(), rand_payload());
    issue(CMD_START, rand_field(), -CAPACITY, rand_payload());

    round = 0;
    while (items_sent < ITEM_TARGET) begin
      round++;
      issue(CMD_START, rand_field(), pick_head(), rand_payload());
      if (round == 4) begin
        while (fill_level < CAPACITY) build_chain($urandom_range(4, 12));
        issue(CMD_LOAD, rand_field(), rand_null(), rand_payload());
        issue(CMD_INSERT, NULL_SLOT, rand_field(), rand_payload());
        issue(CMD_INSERT, $urandom_range(0, CAPACITY - 1), rand_field(), rand_payload());
        issue(CMD_START, rand_field(), pick_written_slot(), rand_payload());
        issue(CMD_WALK, rand_field(), rand_field(), rand_payload());
      end else begin
        repeat ($urandom_range(4, 20)) begin
          r = $urandom_range(0, 99);
          n = $urandom_range(0, 99);
          if (r < 30) begin
            build_chain($urandom_range(1, 6));
          end else if (r < 55) begin
            if (n < 35 || fill_level == 0) issue(CMD_INSERT, rand_null(), rand_field(),
                                                 rand_payload());
            else if (n < 85) issue(CMD_INSERT, $urandom_range(0, fill_level - 1), rand_field(),
                                   rand_payload());
            else issue(CMD_INSERT, $urandom_range(fill_level < CAPACITY ? fill_level : 0,
                                                  CAPACITY - 1), rand_field(), rand_payload());
          end else if (r < 78) begin
            if (n < 40 || fill_level == 0) issue(CMD_DELETE, rand_null(), rand_field(),
                                                 rand_payload());
            else if (n < 90) issue(CMD_DELETE, $urandom_range(0, fill_level - 1), rand_field(),
                                   rand_payload());
            else issue(CMD_DELETE, $urandom_range(fill_level < CAPACITY ? fill_level : 0,
                                                  CAPACITY - 1), rand_field(), rand_payload());
          end else if (r < 90) begin
            issue(CMD_WALK, rand_field(), rand_field(), rand_payload());
          end else if (r < 95) begin
            issue(CMD_W'($urandom_range(CMD_WALK + 1, CMD_TOP)), rand_field(), rand_field(),
                  rand_payload());
          end else begin
            issue(CMD_START, rand_field(), pick_head(), rand_payload());
          end
        end
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2 * CAPACITY) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
